### sv/dsbs_pkg.sv
`timescale 1ns / 1ps
// Package for the DCT sharpness burst selector: command codes, field widths,
// constants and the high-frequency position test. Depends on nothing.
package dsbs_pkg;

    localparam int TS_W        = 40;
    localparam int COEFF_W     = 16;
    localparam int POS_W       = 6;
    localparam int CMD_W       = 2;
    localparam int SCORE_W     = 32;
    localparam int INDEX_BITS  = 16;
    localparam int GAP_W       = 16;

    localparam logic [GAP_W-1:0]      DEFAULT_GAP = GAP_W'(50);
    localparam logic [INDEX_BITS-1:0] COUNT_MAX   = {INDEX_BITS{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_COEFF = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_t;

    typedef logic [TS_W-1:0]       ts_t;
    typedef logic [SCORE_W-1:0]    score_t;
    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [GAP_W-1:0]      gap_t;
    typedef logic [POS_W-1:0]      pos_t;

    // Zigzag rank 32 to 63: anti-diagonal of 8 or more, or anti-diagonal 7
    // from row 4 down.
    function automatic logic is_high_freq(input pos_t pos);
        logic [3:0] diag;
        diag = {1'b0, pos[5:3]} + {1'b0, pos[2:0]};
        return (diag >= 4'd8) || ((diag == 4'd7) && pos[5]);
    endfunction

endpackage

### sv/dsbs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the burst selector input and result beats.
// Depends on dsbs_pkg for the payload types.
interface dsbs_in_if;
    logic                          valid;
    logic                          ready;
    logic [dsbs_pkg::CMD_W-1:0]    command;
    logic signed [dsbs_pkg::COEFF_W-1:0] coeff_value;
    logic [dsbs_pkg::POS_W-1:0]    coeff_position;
    logic [dsbs_pkg::TS_W-1:0]     timestamp;

    modport source (output valid, command, coeff_value, coeff_position, timestamp,
                    input ready);
    modport sink (input valid, command, coeff_value, coeff_position, timestamp,
                  output ready);
endinterface

interface dsbs_out_if;
    logic                              valid;
    logic                              ready;
    logic [dsbs_pkg::INDEX_BITS-1:0]   sharpest_index;
    logic [dsbs_pkg::INDEX_BITS-1:0]   burst_size;
    logic [dsbs_pkg::SCORE_W-1:0]      best_score;

    modport source (output valid, sharpest_index, burst_size, best_score, input ready);
    modport sink (input valid, sharpest_index, burst_size, best_score, output ready);
endinterface

### sv/dct_sharpness_burst_selector_core.sv
`timescale 1ns / 1ps
// Burst sharpness selector core: scores images by high-frequency DCT energy
// and reports the sharpest image of each burst. Depends on dsbs_pkg, dsbs_if.
// A closing beat passes through the input register and then the result register,
// which presents the result beat.
// Throughput: one input beat per cycle; the input and result registers each stall
// only while the result register holds a beat that the sink has not taken.
// Reset (rst_n low, asynchronous) clears all burst state and sets the gap to 50.
module dct_sharpness_burst_selector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        gap_we,
    input  logic [dsbs_pkg::GAP_W-1:0]  gap_wdata,
    dsbs_in_if.sink                     in_ch,
    dsbs_out_if.source                  out_ch
);
    import dsbs_pkg::*;

    // The configuration register holds the largest timestamp gap, in
    // centiseconds, that keeps consecutive images in one burst.
    gap_t gap_reg;

    // Input register stage. The beat is captured here and processed against the
    // burst state when the stage fires.
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic signed [COEFF_W-1:0] s1_coeff_reg;
    pos_t              s1_pos_reg;
    ts_t               s1_ts_reg;
    logic              s1_fire;

    // Burst state.
    score_t score_reg, score_next;
    score_t best_score_reg, best_score_next;
    index_t sharp_index_reg, sharp_index_next;
    index_t count_reg, count_next;
    ts_t    last_time_reg, last_time_next;
    logic   image_open_reg, image_open_next;
    logic   burst_open_reg, burst_open_next;

    // Result register.
    logic   out_valid_reg;
    index_t out_index_reg, out_index_next;
    index_t out_size_reg, out_size_next;
    score_t out_score_reg, out_score_next;
    logic   emit;

    // Helpers for the closing of the open image and the gap test.
    logic                 closed_better;
    score_t               closed_score;
    index_t               closed_index;
    logic [COEFF_W-1:0]   coeff_mag;
    logic signed [TS_W:0] gap;
    logic                 gap_exceeded;

    // The input stage advances whenever the result register can take a beat,
    // so the block stops accepting once it holds a beat behind a waiting result.
    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= DEFAULT_GAP;
        end
        else if (gap_we)
        begin
            gap_reg <= gap_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_cmd_reg   <= in_ch.command;
            s1_coeff_reg <= in_ch.coeff_value;
            s1_pos_reg   <= in_ch.coeff_position;
            s1_ts_reg    <= in_ch.timestamp;
        end
    end

    // Magnitude of a 16-bit signed value fits 16 unsigned bits, including the
    // most negative code.
    assign coeff_mag = s1_coeff_reg[COEFF_W-1] ? COEFF_W'(-s1_coeff_reg)
                                               : COEFF_W'(s1_coeff_reg);

    // Signed gap between the new start timestamp and the previous one. A
    // timestamp that runs backwards gives a negative gap and keeps the burst.
    assign gap          = $signed({1'b0, s1_ts_reg}) - $signed({1'b0, last_time_reg});
    assign gap_exceeded = gap > $signed({{(TS_W + 1 - GAP_W){1'b0}}, gap_reg});

    // Closing an image: a strictly greater score takes the burst best, so the
    // earliest image wins a tie.
    assign closed_better = image_open_reg && (score_reg > best_score_reg);
    assign closed_score  = closed_better ? score_reg : best_score_reg;
    assign closed_index  = !closed_better ? sharp_index_reg :
                           (count_reg != '0) ? count_reg - index_t'(1) : '0;

    always_comb
    begin
        score_next       = score_reg;
        best_score_next  = best_score_reg;
        sharp_index_next = sharp_index_reg;
        count_next       = count_reg;
        last_time_next   = last_time_reg;
        image_open_next  = image_open_reg;
        burst_open_next  = burst_open_reg;
        emit             = 1'b0;
        out_index_next   = closed_index;
        out_size_next    = count_reg;
        out_score_next   = closed_score;

        unique case (s1_cmd_reg)
            CMD_COEFF:
            begin
                // Coefficients with no open image are dropped.
                if (image_open_reg && is_high_freq(s1_pos_reg))
                begin
                    score_next = score_reg + SCORE_W'(coeff_mag);
                end
            end
            CMD_START:
            begin
                best_score_next  = closed_score;
                sharp_index_next = closed_index;
                if (burst_open_reg && gap_exceeded)
                begin
                    emit             = 1'b1;
                    best_score_next  = '0;
                    sharp_index_next = '0;
                    count_next       = index_t'(1);
                end
                else if (count_reg != COUNT_MAX)
                begin
                    // The count saturates; later images share the last index.
                    count_next = count_reg + index_t'(1);
                end
                burst_open_next = 1'b1;
                image_open_next = 1'b1;
                score_next      = '0;
                last_time_next  = s1_ts_reg;
            end
            CMD_FLUSH:
            begin
                best_score_next  = closed_score;
                sharp_index_next = closed_index;
                image_open_next  = 1'b0;
                score_next       = '0;
                // A flush with no open burst produces nothing.
                if (burst_open_reg)
                begin
                    emit             = 1'b1;
                    burst_open_next  = 1'b0;
                    count_next       = '0;
                    best_score_next  = '0;
                    sharp_index_next = '0;
                end
            end
            default:
            begin
                // The unused command code is ignored.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg       <= '0;
            best_score_reg  <= '0;
            sharp_index_reg <= '0;
            count_reg       <= '0;
            last_time_reg   <= '0;
            image_open_reg  <= 1'b0;
            burst_open_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            score_reg       <= score_next;
            best_score_reg  <= best_score_next;
            sharp_index_reg <= sharp_index_next;
            count_reg       <= count_next;
            last_time_reg   <= last_time_next;
            image_open_reg  <= image_open_next;
            burst_open_reg  <= burst_open_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            out_index_reg <= out_index_next;
            out_size_reg  <= out_size_next;
            out_score_reg <= out_score_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sharpest_index = out_index_reg;
    assign out_ch.burst_size     = out_size_reg;
    assign out_ch.best_score     = out_score_reg;

endmodule

### tb/dct_sharpness_burst_selector_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dct_sharpness_burst_selector_core, built from a burst
// scoring model and a result scoreboard. Depends on dsbs_pkg, dsbs_if and the core.
module dct_sharpness_burst_selector_core_tb;
    import dsbs_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1000000;
    // A closing beat passes through the core's input register and then its result
    // register; the drain pause gives such beats time to clear.
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One closed burst as the result channel carries it.
    typedef struct packed {
        index_t sharpest_index;
        index_t burst_size;
        score_t best_score;
    } burst_result_t;

    // Burst scoring model and the queue of burst results it has predicted.
    // note_beat() advances the model by one accepted input beat; check_result()
    // compares one accepted result beat with the oldest prediction.
    class burst_scoreboard;
        gap_t          gap_limit;
        score_t        open_score;
        score_t        top_score;
        index_t        top_index;
        index_t        image_count;
        ts_t           last_stamp;
        bit            image_open;
        bit            burst_open;
        burst_result_t pending[$];
        int            predicted;
        int            mismatches;

        function new();
            gap_limit   = DEFAULT_GAP;
            open_score  = '0;
            top_score   = '0;
            top_index   = '0;
            image_count = '0;
            last_stamp  = '0;
            image_open  = 1'b0;
            burst_open  = 1'b0;
            predicted   = 0;
            mismatches  = 0;
        endfunction

        function void set_gap(gap_t value);
            gap_limit = value;
        endfunction

        // Positions in the upper half of the zigzag scan.
        function bit high_band(pos_t pos);
            int row;
            int col;
            row = pos / 8;
            col = pos % 8;
            return (row + col > 7) || (row + col == 7 && row > 3);
        endfunction

        function void close_image();
            if (image_open)
            begin
                // Strictly greater only, so the earliest image keeps a tie.
                if (open_score > top_score)
                begin
                    top_score = open_score;
                    top_index = (image_count != 0) ? image_count - 1'b1 : '0;
                end
                image_open = 1'b0;
                open_score = '0;
            end
        endfunction

        function void close_burst();
            burst_result_t r;
            r.sharpest_index = top_index;
            r.burst_size     = image_count;
            r.best_score     = top_score;
            pending = {pending, r};
            predicted++;
            burst_open  = 1'b0;
            image_count = '0;
            top_score   = '0;
            top_index   = '0;
        endfunction

        function void note_beat(logic [CMD_W-1:0] cmd, logic signed [COEFF_W-1:0] value,
                                pos_t pos, ts_t stamp);
            int     mag;
            longint gap;
            case (cmd)
                CMD_COEFF:
                begin
                    if (image_open && high_band(pos))
                    begin
                        mag = value;
                        if (mag < 0)
                            mag = -mag;
                        open_score += score_t'(mag);
                    end
                end
                CMD_START:
                begin
                    gap = longint'({24'd0, stamp}) - longint'({24'd0, last_stamp});
                    close_image();
                    if (burst_open && gap > longint'({48'd0, gap_limit}))
                        close_burst();
                    burst_open = 1'b1;
                    if (image_count != COUNT_MAX)
                        image_count++;
                    image_open = 1'b1;
                    open_score = '0;
                    last_stamp = stamp;
                end
                CMD_FLUSH:
                begin
                    close_image();
                    if (burst_open)
                        close_burst();
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(index_t idx, index_t size, score_t score);
            burst_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: index %0d size %0d score %0d",
                             idx, size, score);
                return;
            end
            want = pending.pop_front();
            if (want.sharpest_index !== idx || want.burst_size !== size ||
                want.best_score !== score)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display(
                        "result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d (index/size/score)",
                        want.sharpest_index, want.burst_size, want.best_score,
                        idx, size, score);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       gap_we;
    gap_t       gap_wdata;

    dsbs_in_if  in_ch();
    dsbs_out_if out_ch();

    dct_sharpness_burst_selector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .gap_we    (gap_we),
        .gap_wdata (gap_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    burst_scoreboard sb = new();

    // Idle rates in percent for the two sides; the main process changes them
    // between and within phases.
    int   send_idle_pct = 30;
    int   recv_idle_pct = 73;
    // Each flip of this bit asks the result side for one long hold-off.
    bit   hold_toggle   = 1'b0;
    int   cycle_count   = 0;
    // Timestamp of the last start beat sent, and the gap the core now uses;
    // the stimulus picks gaps relative to both.
    ts_t  ts_cursor;
    gap_t cur_gap       = DEFAULT_GAP;

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Watchdog: a hung handshake or a result that never arrives ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** dct_sharpness_burst_selector_core: FAILED **");
            $finish;
        end
    end

    // Monitor. Both channels are sampled at the rising edge; all testbench
    // drives after time zero are nonblocking, so the values seen here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.sharpest_index, out_ch.burst_size,
                                out_ch.best_score);
            if (in_ch.valid && in_ch.ready)
                sb.note_beat(in_ch.command, in_ch.coeff_value, in_ch.coeff_position,
                             in_ch.timestamp);
        end
    end

    // Result side. Normally ready follows the random idle rate; a flip of
    // hold_toggle pulls it low until the hold-off count runs out, so that results pile
    // up inside the core and its input stalls.
    initial
    begin : result_side
        int hold_left;
        bit seen_toggle;
        hold_left    = 0;
        seen_toggle  = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen_toggle)
            begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one input beat and returns at the edge where it is taken. Valid
    // is left high on return, so back-to-back beats never lower and raise it in
    // the same step; an idle cycle or a drain lowers it. While idle the command, value
    // and position carry random junk so that the core is seen to ignore them.
    task automatic send_beat(input logic [CMD_W-1:0] cmd,
                             input logic signed [COEFF_W-1:0] value,
                             input pos_t pos, input ts_t stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.command        <= CMD_W'($urandom);
            in_ch.coeff_value    <= COEFF_W'($urandom);
            in_ch.coeff_position <= POS_W'($urandom);
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= cmd;
        in_ch.coeff_value    <= value;
        in_ch.coeff_position <= pos;
        in_ch.timestamp      <= stamp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Unused fields of each beat carry random bits.
    task automatic start_image(input ts_t stamp);
        ts_cursor = stamp;
        send_beat(CMD_START, COEFF_W'($urandom), POS_W'($urandom), stamp);
    endtask

    task automatic send_coeff(input logic signed [COEFF_W-1:0] value, input pos_t pos);
        send_beat(CMD_COEFF, value, pos, ts_t'({$urandom, $urandom}));
    endtask

    task automatic send_flush();
        send_beat(CMD_FLUSH, COEFF_W'($urandom), POS_W'($urandom),
                  ts_t'({$urandom, $urandom}));
    endtask

    // Lets the core run dry: input valid drops, every predicted result is
    // taken, and then the drain pause lets beats that closed no burst pass through.
    task automatic drain_core();
        int k;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        for (k = 0; k < DRAIN_CYCLES; k++)
            @(posedge clk);
    endtask

    // The gap register is only written while the core is idle.
    task automatic write_gap(input gap_t value);
        drain_core();
        gap_we    <= 1'b1;
        gap_wdata <= value;
        @(posedge clk);
        gap_we    <= 1'b0;
        sb.set_gap(value);
        cur_gap = value;
    endtask

    function automatic logic signed [COEFF_W-1:0] pick_coeff();
        int k;
        k = $urandom_range(7);
        case (k)
            0:       pick_coeff = 16'sh8000;
            1:       pick_coeff = 16'sh7fff;
            2, 3, 4:
            begin
                k = $urandom_range(400) - 200;
                pick_coeff = k[COEFF_W-1:0];
            end
            default: pick_coeff = COEFF_W'($urandom);
        endcase
    endfunction

    // Next start timestamp: inside the burst (a gap up to the threshold, the
    // threshold itself, or a step back in time), or beyond the threshold.
    function automatic ts_t next_stamp(input bit same_burst);
        longint step;
        int     k;
        k = $urandom_range(9);
        if (same_burst)
        begin
            if (k == 0)
                step = -longint'($urandom_range(1000));
            else if (k < 3)
                step = longint'({48'd0, cur_gap});
            else
                step = longint'($urandom_range(cur_gap));
        end
        else
        begin
            if (k < 3)
                step = longint'({48'd0, cur_gap}) + 1;
            else if (k < 6)
                step = longint'({48'd0, cur_gap}) + 1 + longint'($urandom_range(5000));
            else if (k < 8)
                step = longint'({48'd0, cur_gap}) + 1 + longint'({32'd0, $urandom});
            else
                step = longint'({48'd0, cur_gap}) + 1 + longint'($urandom_range(100));
        end
        return ts_t'(longint'({24'd0, ts_cursor}) + step);
    endfunction

    // Random traffic. Most of it is whole bursts: one to four images with up
    // to a dozen coefficients each, sometimes closed by a flush and otherwise
    // by the next burst's large gap. The rest is noise: the unused command,
    // coefficients with no open image, stray flushes and wild timestamps.
    // Ignored beats do not count toward the item goal.
    task automatic run_random(input int item_goal, input int result_goal);
        int items;
        int results_before;
        int n_img;
        int n_coef;
        int i;
        int j;
        items          = 0;
        results_before = sb.predicted;
        while (items < item_goal || sb.predicted - results_before < result_goal)
        begin
            if ($urandom_range(99) < 85)
            begin
                n_img = $urandom_range(1, 4);
                for (i = 0; i < n_img; i++)
                begin
                    start_image(next_stamp(i != 0));
                    items++;
                    n_coef = $urandom_range(0, 12);
                    for (j = 0; j < n_coef; j++)
                    begin
                        send_coeff(pick_coeff(), POS_W'($urandom_range(63)));
                        items++;
                    end
                end
                if ($urandom_range(1) == 1)
                begin
                    send_flush();
                    items++;
                end
            end
            else
            begin
                case ($urandom_range(3))
                    0: send_beat(CMD_UNUSED, COEFF_W'($urandom), POS_W'($urandom),
                                 ts_t'({$urandom, $urandom}));
                    1:
                    begin
                        send_flush();
                        send_coeff(pick_coeff(), POS_W'($urandom_range(63)));
                    end
                    2:
                    begin
                        start_image(ts_t'({$urandom, $urandom}));
                        items++;
                    end
                    default: send_flush();
                endcase
            end
        end
    endtask

    initial
    begin : main
        int i;
        rst_n                = 1'b0;
        gap_we               = 1'b0;
        gap_wdata            = '0;
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_START;
        in_ch.coeff_value    = '0;
        in_ch.coeff_position = '0;
        in_ch.timestamp      = '0;
        ts_cursor            = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the gap still at its reset value of 50.
        // Beats that must be ignored: a flush with no burst open, a
        // coefficient with no image open, and the unused command.
        send_flush();
        send_coeff(16'sh7fff, 6'd63);
        send_beat(CMD_UNUSED, 16'sh7fff, 6'd63, '1);
        // The first image opens a burst whatever its timestamp. The most
        // negative coefficient lands in the bottom-right corner; a DC coefficient does
        // not count.
        start_image(40'd0);
        send_coeff(16'sh8000, 6'd63);
        send_coeff(16'sh7fff, 6'd0);
        // A gap equal to the threshold keeps the burst; this image has no
        // coefficients and scores zero.
        start_image(40'd50);
        // A step back in time keeps the burst. This image ties the first one
        // (row 4 on the seventh anti-diagonal counts, row 3 does not), and the
        // earlier image keeps the lead.
        start_image(40'd20);
        send_coeff(16'sh7fff, 6'd35);
        send_coeff(16'sh0001, 6'd36);
        send_coeff(16'sh7fff, 6'd28);
        // One past the threshold closes the burst of three.
        start_image(40'd71);
        send_coeff(16'sd5, 6'd28);
        send_flush();
        send_flush();
        // Largest timestamp with no burst open, then the smallest one, which
        // keeps the burst; the second image wins.
        start_image('1);
        send_coeff(16'sd1, 6'd63);
        start_image(40'd0);
        send_coeff(-16'sd2, 6'd62);
        send_flush();

        // Phase A: the sender idles now and then, the receiver mostly, with
        // the smallest threshold.
        write_gap(16'd0);
        ts_cursor = ts_t'({$urandom_range(255), $urandom});
        run_random(450, 20);

        // Phase B: the other way round, with the largest threshold. In the
        // middle the receiver holds off while the sender keeps offering bursts
        // that each close the one before.
        write_gap(16'hffff);
        send_idle_pct = 73;
        recv_idle_pct = 30;
        run_random(225, 10);
        send_idle_pct = 0;
        hold_toggle  <= ~hold_toggle;
        for (i = 0; i < 12; i++)
        begin
            start_image(next_stamp(1'b0));
            send_coeff(pick_coeff(), POS_W'($urandom_range(63)));
        end
        send_idle_pct = 73;
        run_random(225, 10);

        // Phase C: neither side idles, with a threshold in between.
        write_gap(gap_t'($urandom_range(1, 65534)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(450, 20);
        send_flush();

        drain_core();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** dct_sharpness_burst_selector_core: PASSED **");
        else
            $display("** dct_sharpness_burst_selector_core: FAILED **");
        $finish;
    end

endmodule

### files.f
sv/dsbs_pkg.sv
sv/dsbs_if.sv
sv/dct_sharpness_burst_selector_core.sv
tb/dct_sharpness_burst_selector_core_tb.sv
